FILE: rtl/rshe_pkg.sv
// Shared types, constants and rounding helpers for the spherical harmonic evaluator.
package rshe_pkg;

  localparam int DefCoordWidth    = 32;
  localparam int DefResultFrac    = 30;
  localparam int IntFrac          = 30;
  localparam int QW               = 34;   // signed Q.30 working width
  localparam int CfgWidth         = 16;
  localparam int QueueDepth       = 4;

  localparam logic signed [QW-1:0] OneQ = QW'(64'sd1 << IntFrac);

  typedef logic signed [QW-1:0] q_t;

  // Normalization constants by table entry, Q.30.
  function automatic logic [31:0] kconst(input logic [3:0] idx);
    logic [31:0] k;
    case (idx)
      4'd0:    k = 32'd302896976;
      4'd1,
      4'd2,
      4'd3:    k = 32'd524632952;
      4'd4,
      4'd5,
      4'd7:    k = 32'd1173114945;
      4'd6:    k = 32'd338649115;
      4'd8:    k = 32'd586557472;
      4'd9:    k = 32'd633554480;
      4'd10:   k = 32'd3103770403;
      4'd11:   k = 32'd490749190;
      4'd12:   k = 32'd400695036;
      4'd13:   k = 32'd490749190;
      4'd14:   k = 32'd1551885201;
      default: k = 32'd633554480;
    endcase
    return k;
  endfunction

  // Q.30 product, magnitude rounded half up, sign reapplied.
  function automatic q_t qmul(input q_t a, input q_t b);
    logic [QW-1:0]   ma;
    logic [QW-1:0]   mb;
    logic [2*QW-1:0] p;
    logic [2*QW-1:0] s;
    ma = a[QW-1] ? QW'(-a) : QW'(a);
    mb = b[QW-1] ? QW'(-b) : QW'(b);
    p  = ma * mb + ((2*QW)'(1) << (IntFrac - 1));
    s  = p >> IntFrac;
    return (a[QW-1] ^ b[QW-1]) ? -q_t'(s[QW-1:0]) : q_t'(s[QW-1:0]);
  endfunction

  // Classified request passed from the front part to the back part.
  typedef struct packed {
    logic       bad;
    logic       tiny;
    logic [3:0] idx;
  } cls_t;

endpackage

FILE: rtl/real_spherical_harmonic_eval_top.sv
// Real spherical harmonic evaluator, degrees 0 to 3, Cartesian input.
// Accepts one request per cycle.
// The divider pipeline (one quotient bit per stage) sets the latency; busy stays low.
// The receiver cannot stall: done is a one-cycle strobe.
// Synchronous active-high reset clears all valid flags and sets min_radius to 1.
module real_spherical_harmonic_eval_top #(
  parameter int COORD_WIDTH      = rshe_pkg::DefCoordWidth,
  parameter int RESULT_FRAC_BITS = rshe_pkg::DefResultFrac
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    degree,
  input  logic signed [2:0]             order,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  input  logic signed [COORD_WIDTH-1:0] coord_z,
  input  logic [COORD_WIDTH-1:0]        radius,
  input  logic                          cfg_we,
  input  logic [rshe_pkg::CfgWidth-1:0] cfg_data,
  output logic                          done,
  output logic signed [31:0]            harmonic_value,
  output logic                          bad_order
);
  import rshe_pkg::*;

  localparam int QE = $bits(cls_t) + 3 * QW;

  logic [CfgWidth-1:0] min_radius;
  always_ff @(posedge clk) begin
    if (rst) min_radius <= CfgWidth'(1);
    else if (cfg_we) min_radius <= cfg_data;
  end

  // Back part never stalls, so the front always advances.
  assign busy = 1'b0;

  logic f_valid; cls_t f_cls; q_t f_u, f_v, f_w;
  rshe_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .en(1'b1), .take(start),
    .degree(degree), .order(order), .coord_x(coord_x), .coord_y(coord_y),
    .coord_z(coord_z), .radius(radius), .min_radius(min_radius),
    .out_valid(f_valid), .out_cls(f_cls), .out_u(f_u), .out_v(f_v), .out_w(f_w));

  logic          q_ne;
  logic [QE-1:0] q_dout;
  rshe_queue #(.WIDTH(QE), .DEPTH(QueueDepth)) u_queue (
    .clk(clk), .rst(rst), .push(f_valid), .din({f_cls, f_u, f_v, f_w}),
    .pop(q_ne), .not_empty(q_ne), .dout(q_dout));

  rshe_back #(.RESULT_FRAC_BITS(RESULT_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .in_valid(q_ne),
    .in_cls(cls_t'(q_dout[QE-1 -: $bits(cls_t)])),
    .in_u(q_t'(q_dout[3*QW-1 -: QW])), .in_v(q_t'(q_dout[2*QW-1 -: QW])),
    .in_w(q_t'(q_dout[QW-1:0])),
    .done(done), .harmonic_value(harmonic_value), .bad_order(bad_order));
endmodule

FILE: rtl/rshe_div.sv
// Pipelined restoring divider: ratio |c|/r in Q.30 with clamp and sign.
module rshe_div #(
  parameter int COORD_WIDTH = rshe_pkg::DefCoordWidth
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [COORD_WIDTH-1:0]    coord,
  input  logic        [COORD_WIDTH-1:0]    radius,
  output rshe_pkg::q_t                     ratio
);
  import rshe_pkg::*;

  localparam int Steps = IntFrac + 1;
  localparam int RW    = COORD_WIDTH + 1;

  logic [RW-1:0]          rem   [Steps+1];
  logic [Steps-1:0]       acc   [Steps+1];
  logic [COORD_WIDTH-1:0] den   [Steps+1];
  logic                   neg   [Steps+1];
  logic                   clamp [Steps+1];

  logic [COORD_WIDTH-1:0] mag;
  assign mag = coord[COORD_WIDTH-1] ? COORD_WIDTH'(-coord) : COORD_WIDTH'(coord);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= RW'(mag);
      acc[0]   <= '0;
      den[0]   <= radius;
      neg[0]   <= coord[COORD_WIDTH-1];
      clamp[0] <= mag >= radius;
    end
  end

  // One quotient bit per stage.
  for (genvar i = 0; i < Steps; i++) begin : g_stage
    logic [RW:0] sh;
    logic        ge;
    assign sh = {rem[i], 1'b0};
    assign ge = sh >= (RW+1)'(den[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]   <= ge ? RW'(sh - (RW+1)'(den[i])) : RW'(sh);
        acc[i+1]   <= {acc[i][Steps-2:0], ge};
        den[i+1]   <= den[i];
        neg[i+1]   <= neg[i];
        clamp[i+1] <= clamp[i];
      end
    end
  end

  logic [Steps:0] rq;
  q_t             q;
  assign rq = ({1'b0, acc[Steps]} + (Steps+1)'(1)) >> 1;
  assign q  = clamp[Steps] ? OneQ : q_t'(rq);

  always_ff @(posedge clk) begin
    if (en) ratio <= neg[Steps] ? -q : q;
  end
endmodule

FILE: rtl/rshe_front.sv
// Front part: classify requests, compute ratios, feed the queue.
module rshe_front #(
  parameter int COORD_WIDTH = rshe_pkg::DefCoordWidth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          take,
  input  logic [1:0]                    degree,
  input  logic signed [2:0]             order,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  input  logic signed [COORD_WIDTH-1:0] coord_z,
  input  logic [COORD_WIDTH-1:0]        radius,
  input  logic [rshe_pkg::CfgWidth-1:0] min_radius,
  output logic                          out_valid,
  output rshe_pkg::cls_t                out_cls,
  output rshe_pkg::q_t                  out_u,
  output rshe_pkg::q_t                  out_v,
  output rshe_pkg::q_t                  out_w
);
  import rshe_pkg::*;

  localparam int Lat = IntFrac + 3;

  logic signed [3:0] l4;
  logic signed [3:0] m4;
  cls_t              c;
  assign l4      = {2'b00, degree};
  assign m4      = {order[2], order};
  assign c.bad   = (m4 > l4) || (-m4 > l4);
  assign c.tiny  = (radius == '0) || (radius < COORD_WIDTH'(min_radius));
  assign c.idx   = 4'(degree * degree + degree) + 4'(m4);

  logic [Lat-1:0] vld;
  cls_t           cls [Lat];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls[0] <= c;
      for (int i = 1; i < Lat; i++) cls[i] <= cls[i-1];
    end
  end

  rshe_div #(.COORD_WIDTH(COORD_WIDTH)) u_dx (
    .clk(clk), .en(en), .coord(coord_x), .radius(radius), .ratio(out_u));
  rshe_div #(.COORD_WIDTH(COORD_WIDTH)) u_dy (
    .clk(clk), .en(en), .coord(coord_y), .radius(radius), .ratio(out_v));
  rshe_div #(.COORD_WIDTH(COORD_WIDTH)) u_dz (
    .clk(clk), .en(en), .coord(coord_z), .radius(radius), .ratio(out_w));

  assign out_valid = vld[Lat-1];
  assign out_cls   = cls[Lat-1];
endmodule

FILE: rtl/rshe_queue.sv
// Short request queue between front and back parts.
module rshe_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rshe_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] dout
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [AW:0]      cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  assign not_empty = cnt != '0;
  assign dout      = mem[rp];
endmodule

FILE: rtl/rshe_back.sv
// Back part: polynomial, normalization, rescale and saturation pipeline.
module rshe_back #(
  parameter int RESULT_FRAC_BITS = rshe_pkg::DefResultFrac
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  rshe_pkg::cls_t     in_cls,
  input  rshe_pkg::q_t       in_u,
  input  rshe_pkg::q_t       in_v,
  input  rshe_pkg::q_t       in_w,
  output logic               done,
  output logic signed [31:0] harmonic_value,
  output logic               bad_order
);
  import rshe_pkg::*;

  // stage 1: single products
  logic s1v; cls_t c1; q_t u1, v1, w1, uv1, vw1, uw1, ww1, uu1, vv1, dd1;
  always_ff @(posedge clk) begin
    if (rst) s1v <= 1'b0;
    else     s1v <= in_valid;
    c1 <= in_cls; u1 <= in_u; v1 <= in_v; w1 <= in_w;
    uv1 <= qmul(in_u, in_v);
    vw1 <= qmul(in_v, in_w);
    uw1 <= qmul(in_u, in_w);
    ww1 <= qmul(in_w, in_w);
    uu1 <= qmul(in_u, in_u);
    vv1 <= qmul(in_v, in_v);
    dd1 <= qmul(in_u - in_v, in_u + in_v);
  end

  // stage 2: polynomial
  logic s2v; cls_t c2; q_t p2;
  q_t f, g;
  always_comb begin
    f = '0; g = '0;
    case (c1.idx)
      4'd9:    begin f = v1; g = 3 * uu1 - vv1; end
      4'd10:   begin f = uv1; g = w1; end
      4'd11:   begin f = v1; g = 5 * ww1 - OneQ; end
      4'd12:   begin f = w1; g = 5 * ww1 - 3 * OneQ; end
      4'd13:   begin f = u1; g = 5 * ww1 - OneQ; end
      4'd14:   begin f = w1; g = dd1; end
      4'd15:   begin f = u1; g = uu1 - 3 * vv1; end
      default: begin f = '0; g = '0; end
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) s2v <= 1'b0;
    else     s2v <= s1v;
    c2 <= c1;
    case (c1.idx)
      4'd0:    p2 <= OneQ;
      4'd1:    p2 <= v1;
      4'd2:    p2 <= w1;
      4'd3:    p2 <= u1;
      4'd4:    p2 <= uv1;
      4'd5:    p2 <= vw1;
      4'd6:    p2 <= 3 * ww1 - OneQ;
      4'd7:    p2 <= uw1;
      4'd8:    p2 <= dd1;
      default: p2 <= qmul(f, g);
    endcase
  end

  // stage 3: constant times polynomial; small radius takes the l=0 constant
  logic s3v; logic b3; logic signed [QW+1:0] k3;
  always_ff @(posedge clk) begin
    if (rst) s3v <= 1'b0;
    else     s3v <= s2v;
    b3 <= c2.bad;
    if (c2.tiny) k3 <= (QW+2)'(kconst(4'd0));
    else k3 <= (QW+2)'(qmul(q_t'({1'b0, kconst(c2.idx)}), p2));
  end

  // stage 4: rescale and saturate
  logic               neg;
  logic [QW+1:0]      mag;
  logic [QW+IntFrac+47:0] sc;
  logic signed [31:0] res;
  always_comb begin
    neg = k3[QW+1];
    mag = neg ? (QW+2)'(-k3) : (QW+2)'(k3);
    if (RESULT_FRAC_BITS >= IntFrac)
      sc = (QW+IntFrac+48)'(mag) << (RESULT_FRAC_BITS - IntFrac);
    else
      sc = ((QW+IntFrac+48)'(mag) + ((QW+IntFrac+48)'(1) << (IntFrac - RESULT_FRAC_BITS - 1)))
           >> (IntFrac - RESULT_FRAC_BITS);
    if (neg) res = (sc > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(sc[31:0]);
    else     res = (sc > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(sc[31:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= s3v;
    harmonic_value <= b3 ? 32'sd0 : res;
    bad_order      <= b3;
  end
endmodule
